### design/rpbb_pkg.sv
// ----------------------------------------------------------------------------
// Rotated point bounding box package
// Item types, field widths and configuration register indexes shared by the
// bounding box design.
// ----------------------------------------------------------------------------
package rpbb_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int HALF_WIDTH    = COORD_WIDTH - 1;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 3;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROT_XX = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROT_XY = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROT_YX = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROT_YY = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_POS_X  = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_POS_Y  = 3'd5;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic                          recompute;
        logic                          last_point;
    } t_point_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic        [HALF_WIDTH-1:0]  half_x;
        logic        [HALF_WIDTH-1:0]  half_y;
        logic                          updated;
    } t_box_out;

endpackage

### design/rotated_point_bounding_box.sv
// ----------------------------------------------------------------------------
// Rotated point bounding box
// A result leaves the output register once the last point of a run has passed
// the input, rotation and snapshot registers. Throughput: one point per cycle
// while the output is not stalled, set by the single four-register pipeline.
// Reset (synchronous, active low) loads the identity matrix, a zero position,
// a zero stored box and an empty run.
// ----------------------------------------------------------------------------
module rotated_point_bounding_box #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rpbb_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  logic [rpbb_pkg::CFG_WIDTH-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  rpbb_pkg::t_point_in                  i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output rpbb_pkg::t_box_out                   o_out
);

    localparam int CW     = rpbb_pkg::COORD_WIDTH;
    localparam int PROD_W = rpbb_pkg::CFG_WIDTH + CW;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic signed [SUM_W-1:0] ROUND  = SUM_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(2 ** (CW - 1) - 1);
    localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_HI - SUM_W'(1);

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [CW-1:0] res;
        if (v > SUM_HI) begin
            res = SUM_HI[CW-1:0];
        end else if (v < SUM_LO) begin
            res = SUM_LO[CW-1:0];
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic signed [rpbb_pkg::CFG_WIDTH-1:0] r_rot_xx, r_rot_xy, r_rot_yx, r_rot_yy;
    logic signed [rpbb_pkg::CFG_WIDTH-1:0] r_pos_x, r_pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_xx <= rpbb_pkg::CFG_WIDTH'(16384);
            r_rot_xy <= '0;
            r_rot_yx <= '0;
            r_rot_yy <= rpbb_pkg::CFG_WIDTH'(16384);
            r_pos_x  <= '0;
            r_pos_y  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpbb_pkg::CFG_ROT_XX: r_rot_xx <= i_cfg_data;
                rpbb_pkg::CFG_ROT_XY: r_rot_xy <= i_cfg_data;
                rpbb_pkg::CFG_ROT_YX: r_rot_yx <= i_cfg_data;
                rpbb_pkg::CFG_ROT_YY: r_rot_yy <= i_cfg_data;
                rpbb_pkg::CFG_POS_X:  r_pos_x  <= i_cfg_data;
                rpbb_pkg::CFG_POS_Y:  r_pos_y  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic en;
    logic r_out_valid;
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Stage 0: input register.
    logic                r_s0_valid;
    rpbb_pkg::t_point_in r_s0;

    // Stage 1: rotated coordinates.
    logic                 r_s1_valid, r_s1_recompute, r_s1_last;
    logic signed [CW-1:0] r_s1_rx, r_s1_ry;

    logic signed [PROD_W-1:0] prod_xx, prod_xy, prod_yx, prod_yy;
    logic signed [SUM_W-1:0]  sum_x, sum_y, sh_x, sh_y;

    always_comb begin
        prod_xx = PROD_W'(r_rot_xx) * PROD_W'(r_s0.point_x);
        prod_xy = PROD_W'(r_rot_xy) * PROD_W'(r_s0.point_y);
        prod_yx = PROD_W'(r_rot_yx) * PROD_W'(r_s0.point_x);
        prod_yy = PROD_W'(r_rot_yy) * PROD_W'(r_s0.point_y);
        sum_x   = SUM_W'(prod_xx) + SUM_W'(prod_xy) + ROUND;
        sum_y   = SUM_W'(prod_yx) + SUM_W'(prod_yy) + ROUND;
        sh_x    = sum_x >>> FRAC_BITS;
        sh_y    = sum_y >>> FRAC_BITS;
    end

    // Stage 2: running extremes and a snapshot of them at the end of a run.
    logic                 r_run_started;
    logic signed [CW-1:0] r_run_min_x, r_run_max_x, r_run_min_y, r_run_max_y;
    logic signed [CW-1:0] n_run_min_x, n_run_max_x, n_run_min_y, n_run_max_y;
    logic                 r_s2_valid, r_s2_updated;
    logic signed [CW-1:0] r_s2_min_x, r_s2_max_x, r_s2_min_y, r_s2_max_y;

    always_comb begin
        n_run_min_x = r_run_min_x;
        n_run_max_x = r_run_max_x;
        n_run_min_y = r_run_min_y;
        n_run_max_y = r_run_max_y;
        if (r_s1_recompute) begin
            if (!r_run_started) begin
                n_run_min_x = r_s1_rx;
                n_run_max_x = r_s1_rx;
                n_run_min_y = r_s1_ry;
                n_run_max_y = r_s1_ry;
            end else begin
                if (r_s1_rx < r_run_min_x) n_run_min_x = r_s1_rx;
                if (r_s1_rx > r_run_max_x) n_run_max_x = r_s1_rx;
                if (r_s1_ry < r_run_min_y) n_run_min_y = r_s1_ry;
                if (r_s1_ry > r_run_max_y) n_run_max_y = r_s1_ry;
            end
        end
    end

    // Stage 3: box from the snapshot.
    logic signed [CW:0]   mid_sum_x, mid_sum_y, mid_x, mid_y;
    logic signed [CW+1:0] cen_x, cen_y;
    logic        [CW:0]   diff_x, diff_y;
    rpbb_pkg::t_box_out   n_box;

    logic signed [CW-1:0]               r_box_center_x, r_box_center_y;
    logic [rpbb_pkg::HALF_WIDTH-1:0]    r_box_half_x, r_box_half_y;
    rpbb_pkg::t_box_out                 r_out;

    always_comb begin
        mid_sum_x = (CW + 1)'(r_s2_max_x) + (CW + 1)'(r_s2_min_x);
        mid_sum_y = (CW + 1)'(r_s2_max_y) + (CW + 1)'(r_s2_min_y);
        mid_x     = mid_sum_x >>> 1;
        mid_y     = mid_sum_y >>> 1;
        cen_x     = (CW + 2)'(mid_x) + (CW + 2)'(r_pos_x);
        cen_y     = (CW + 2)'(mid_y) + (CW + 2)'(r_pos_y);
        diff_x    = (CW + 1)'(r_s2_max_x) - (CW + 1)'(r_s2_min_x);
        diff_y    = (CW + 1)'(r_s2_max_y) - (CW + 1)'(r_s2_min_y);
        if (r_s2_updated) begin
            n_box.center_x = sat_coord(SUM_W'(cen_x));
            n_box.center_y = sat_coord(SUM_W'(cen_y));
            n_box.half_x   = diff_x[CW-1:1];
            n_box.half_y   = diff_y[CW-1:1];
            n_box.updated  = 1'b1;
        end else begin
            n_box.center_x = r_box_center_x;
            n_box.center_y = r_box_center_y;
            n_box.half_x   = r_box_half_x;
            n_box.half_y   = r_box_half_y;
            n_box.updated  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid     <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_run_started  <= 1'b0;
            r_run_min_x    <= '0;
            r_run_max_x    <= '0;
            r_run_min_y    <= '0;
            r_run_max_y    <= '0;
            r_box_center_x <= '0;
            r_box_center_y <= '0;
            r_box_half_x   <= '0;
            r_box_half_y   <= '0;
        end else if (en) begin
            r_s0_valid  <= i_in_valid;
            r_s1_valid  <= r_s0_valid;
            r_s2_valid  <= r_s1_valid && r_s1_last;
            r_out_valid <= r_s2_valid;
            if (r_s1_valid) begin
                r_run_min_x <= n_run_min_x;
                r_run_max_x <= n_run_max_x;
                r_run_min_y <= n_run_min_y;
                r_run_max_y <= n_run_max_y;
                if (r_s1_last) begin
                    r_run_started <= 1'b0;
                end else if (r_s1_recompute) begin
                    r_run_started <= 1'b1;
                end
            end
            if (r_s2_valid) begin
                r_box_center_x <= n_box.center_x;
                r_box_center_y <= n_box.center_y;
                r_box_half_x   <= n_box.half_x;
                r_box_half_y   <= n_box.half_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0           <= i_in;
            r_s1_rx        <= sat_coord(sh_x);
            r_s1_ry        <= sat_coord(sh_y);
            r_s1_recompute <= r_s0.recompute;
            r_s1_last      <= r_s0.last_point;
            r_s2_updated   <= r_s1_recompute;
            r_s2_min_x     <= n_run_min_x;
            r_s2_max_x     <= n_run_max_x;
            r_s2_min_y     <= n_run_min_y;
            r_s2_max_y     <= n_run_max_y;
            r_out          <= n_box;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s2_valid) |=> r_out_valid)
        else $error("End of run did not produce a result item.");

    a_run_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_started |-> (r_run_min_x <= r_run_max_x) && (r_run_min_y <= r_run_max_y))
        else $error("Running minimum exceeds running maximum.");

    a_out_matches_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.center_x == r_box_center_x)
            && (r_out.center_y == r_box_center_y)
            && (r_out.half_x == r_box_half_x) && (r_out.half_y == r_box_half_y))
        else $error("Result item differs from the stored box.");

endmodule

### sim/tb_rotated_point_bounding_box.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotated point bounding box testbench
// Polygon runs are pushed through the block under several matrix and
// position settings. A behavioural predictor builds the expected box for
// every finished run, and each output item is checked against it field by
// field. Both handshakes idle in random bursts, and one long output stall
// forces the block to back up.
// ----------------------------------------------------------------------------
module tb_rotated_point_bounding_box;

    localparam int  COORD_WIDTH   = rpbb_pkg::COORD_WIDTH;
    localparam int  HALF_WIDTH    = rpbb_pkg::HALF_WIDTH;
    localparam int  CFG_WIDTH     = rpbb_pkg::CFG_WIDTH;
    localparam int  CFG_IDX_WIDTH = rpbb_pkg::CFG_IDX_WIDTH;
    localparam int  FRAC_BITS   = 14;
    localparam int  QUIET_LIMIT = 2000;
    localparam int  HOLD_CYCLES = 400;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx   = '0;
    logic [CFG_WIDTH-1:0]     i_cfg_data  = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_ready;
    rpbb_pkg::t_point_in      i_in        = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    rpbb_pkg::t_box_out       o_out;

    rotated_point_bounding_box #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out(o_out)
    );

    // Predictor copy of the configuration and of the run state.
    logic signed [COORD_WIDTH-1:0] mat_xx = 16'sd16384;
    logic signed [COORD_WIDTH-1:0] mat_xy = '0;
    logic signed [COORD_WIDTH-1:0] mat_yx = '0;
    logic signed [COORD_WIDTH-1:0] mat_yy = 16'sd16384;
    logic signed [COORD_WIDTH-1:0] offset_x = '0;
    logic signed [COORD_WIDTH-1:0] offset_y = '0;
    logic signed [COORD_WIDTH-1:0] ext_min_x = '0, ext_max_x = '0;
    logic signed [COORD_WIDTH-1:0] ext_min_y = '0, ext_max_y = '0;
    bit                            run_open  = 1'b0;
    rpbb_pkg::t_box_out            stored_box = '0;

    rpbb_pkg::t_point_in pending_points[$];
    rpbb_pkg::t_box_out  box_expected[$];

    bit idle_on     = 1'b1;
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int stall_left  = 0;
    int send_gap    = 0;
    int quiet       = 0;
    int mismatches  = 0;
    int points_sent = 0;
    int boxes_seen  = 0;
    int boxes_fresh = 0;
    int cfg_sets    = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(longint v);
        longint c;
        c = (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
        return c[COORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] rotate_coord(
        logic signed [COORD_WIDTH-1:0] a, logic signed [COORD_WIDTH-1:0] b,
        logic signed [COORD_WIDTH-1:0] px, logic signed [COORD_WIDTH-1:0] py);
        longint acc;
        acc = longint'(a) * longint'(px) + longint'(b) * longint'(py)
            + (longint'(1) <<< (FRAC_BITS - 1));
        return sat_coord(acc >>> FRAC_BITS);
    endfunction

    // Advances the run state by one point; returns 1 when a box item is due.
    function automatic bit predict_box(rpbb_pkg::t_point_in p,
                                       output rpbb_pkg::t_box_out box);
        logic signed [COORD_WIDTH-1:0] rx, ry;
        longint span_x, span_y;
        box = '0;
        if (p.recompute) begin
            rx = rotate_coord(mat_xx, mat_xy, p.point_x, p.point_y);
            ry = rotate_coord(mat_yx, mat_yy, p.point_x, p.point_y);
            if (!run_open) begin
                ext_min_x = rx; ext_max_x = rx;
                ext_min_y = ry; ext_max_y = ry;
                run_open = 1'b1;
            end else begin
                if (rx < ext_min_x) ext_min_x = rx;
                if (rx > ext_max_x) ext_max_x = rx;
                if (ry < ext_min_y) ext_min_y = ry;
                if (ry > ext_max_y) ext_max_y = ry;
            end
        end
        if (!p.last_point) return 1'b0;
        if (p.recompute) begin
            span_x = (longint'(ext_max_x) - longint'(ext_min_x)) >>> 1;
            span_y = (longint'(ext_max_y) - longint'(ext_min_y)) >>> 1;
            stored_box.half_x   = span_x[HALF_WIDTH-1:0];
            stored_box.half_y   = span_y[HALF_WIDTH-1:0];
            stored_box.center_x = sat_coord(((longint'(ext_max_x) + longint'(ext_min_x)) >>> 1)
                                            + longint'(offset_x));
            stored_box.center_y = sat_coord(((longint'(ext_max_y) + longint'(ext_min_y)) >>> 1)
                                            + longint'(offset_y));
        end
        run_open = 1'b0;
        box = stored_box;
        box.updated = p.recompute;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Point driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                i_in       <= pending_points.pop_front();
                i_in_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 15);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Box receiver, with random stalls and the long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 14);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: predicts on each accepted point and checks each accepted box.
    always @(posedge i_clk) begin
        rpbb_pkg::t_box_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                boxes_seen++;
                if (box_expected.size() == 0) begin
                    $display("%0t: unexpected box item, expected none, actual %h", $time, o_out);
                    mismatches++;
                end else begin
                    want = box_expected.pop_front();
                    if (want.updated) boxes_fresh++;
                    check_field("center_x", want.center_x, o_out.center_x);
                    check_field("center_y", want.center_y, o_out.center_y);
                    check_field("half_x", want.half_x, o_out.half_x);
                    check_field("half_y", want.half_y, o_out.half_y);
                    check_field("updated", want.updated, o_out.updated);
                end
            end
            if (i_in_valid && o_in_ready) begin
                points_sent++;
                if (predict_box(i_in, want)) box_expected.push_back(want);
            end
        end
    end

    // Watchdog on handshake activity.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic push_point(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y,
                              bit recompute, bit last_point);
        rpbb_pkg::t_point_in p;
        p.point_x    = x;
        p.point_y    = y;
        p.recompute  = recompute;
        p.last_point = last_point;
        pending_points.push_back(p);
    endtask

    function automatic logic [COORD_WIDTH-1:0] random_coord();
        if ($urandom_range(0, 1)) return COORD_WIDTH'($urandom);
        return COORD_WIDTH'(int'($urandom_range(0, 4000)) - 2000);
    endfunction

    // Mostly clean runs, some fully ignored and some with mixed recompute.
    task automatic push_run(int len);
        int mode;
        bit rc;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < len; k++) begin
            rc = (mode == 0) ? 1'b0 : ((mode == 1) ? bit'($urandom_range(0, 1)) : 1'b1);
            push_point(random_coord(), random_coord(), rc, k == len - 1);
        end
    endtask

    task automatic wait_idle(int settle);
        while (pending_points.size() > 0 || i_in_valid || box_expected.size() > 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_config(logic [CFG_WIDTH-1:0] xx, logic [CFG_WIDTH-1:0] xy,
                              logic [CFG_WIDTH-1:0] yx, logic [CFG_WIDTH-1:0] yy,
                              logic [CFG_WIDTH-1:0] px, logic [CFG_WIDTH-1:0] py);
        logic [CFG_IDX_WIDTH-1:0] idx [6];
        logic [CFG_WIDTH-1:0]     val [6];
        idx = '{rpbb_pkg::CFG_ROT_XX, rpbb_pkg::CFG_ROT_XY, rpbb_pkg::CFG_ROT_YX,
                rpbb_pkg::CFG_ROT_YY, rpbb_pkg::CFG_POS_X, rpbb_pkg::CFG_POS_Y};
        val = '{xx, xy, yx, yy, px, py};
        for (int k = 0; k < 6; k++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mat_xx = xx; mat_xy = xy; mat_yx = yx; mat_yy = yy;
        offset_x = px; offset_y = py;
        cfg_sets++;
    endtask

    initial begin
        int target;
        logic [CFG_WIDTH-1:0] m [4];
        logic [CFG_WIDTH-1:0] ox, oy;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: stored box before any run, extremes, mixed runs.
        push_point(16'sd0, 16'sd0, 1'b0, 1'b1);
        push_point(16'sh7fff, 16'sh8000, 1'b1, 1'b1);
        push_point(16'sh8000, 16'sh8000, 1'b1, 1'b0);
        push_point(16'sh7fff, 16'sh7fff, 1'b1, 1'b1);
        push_point(16'sd100, 16'sd100, 1'b1, 1'b0);
        push_point(-16'sd30000, 16'sd30000, 1'b0, 1'b0);
        push_point(-16'sd100, 16'sd50, 1'b1, 1'b1);
        push_point(16'sd5000, 16'sd5000, 1'b1, 1'b0);
        push_point(16'sd0, 16'sd0, 1'b0, 1'b1);
        push_point(16'sd7, -16'sd7, 1'b1, 1'b1);
        push_point(16'sd1234, -16'sd4321, 1'b0, 1'b0);
        push_point(16'sd1, 16'sd1, 1'b0, 1'b1);
        wait_idle(8);

        // Negative matrix at full scale: rotated points overflow and saturate.
        set_config(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
                   16'sh7fff, 16'sh8000);
        push_point(16'sh7fff, 16'sh7fff, 1'b1, 1'b0);
        push_point(16'sh8000, 16'sh8000, 1'b1, 1'b1);
        push_point(16'sh8000, 16'sh8000, 1'b1, 1'b1);
        wait_idle(8);

        // Matrix entries at the ends of the Q1.14 range.
        set_config(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        push_point(16'sh7fff, 16'sh8000, 1'b1, 1'b1);
        push_point(16'sh8000, 16'sh7fff, 1'b1, 1'b0);
        push_point(16'hffff, 16'sd1, 1'b1, 1'b1);
        wait_idle(8);

        // Quarter turn while the receiver holds off and the block backs up.
        set_config(16'sd0, -16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        hold_asked++;
        for (int k = 0; k < 40; k++) push_run($urandom_range(1, 2));
        wait_idle(8);

        for (int phase = 0; phase < 6; phase++) begin
            for (int k = 0; k < 4; k++)
                m[k] = ($urandom_range(0, 9) < 7)
                     ? CFG_WIDTH'(int'($urandom_range(0, 32768)) - 16384)
                     : CFG_WIDTH'($urandom);
            case ($urandom_range(0, 4))
                0: begin ox = 16'sh7fff; oy = 16'sh8000; end
                1: begin ox = 16'sh8000; oy = 16'sh7fff; end
                default: begin ox = random_coord(); oy = random_coord(); end
            endcase
            set_config(m[0], m[1], m[2], m[3], ox, oy);
            if (phase == 5) idle_on = 1'b0;
            target = points_sent + pending_points.size() + 95;
            while (points_sent + pending_points.size() < target) begin
                push_run(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                     : $urandom_range(1, 8));
                if (pending_points.size() > 16) @(posedge i_clk);
            end
            wait_idle(8);
        end

        wait_idle(20);
        $display("Covered %0d points and %0d box items (%0d rebuilt) over %0d register settings,",
                 points_sent, boxes_seen, boxes_fresh, cfg_sets + 1);
        $display("with saturating matrices, ignored and mixed runs, and a long output hold-off.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
